@@ sv/ogls_pkg.sv @@
// Shared types, codes and constants of the Ogg lacing sample splitter.
package ogls_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned SEGMENT_DIVISOR_DEF = 5;
  localparam int unsigned EV_QUEUE_DEPTH_DEF  = 2;
  localparam int unsigned OUT_QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int unsigned OFFSET_W    = 48;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned DUR_W       = 31;
  localparam int unsigned HDUR_W      = 32;
  localparam int unsigned START_W     = 17;
  localparam int unsigned FRAME_W     = 16;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned CFG_INDEX_W = 1;

  // Limits and magic values
  localparam logic [SIZE_W-1:0]  MAX_PACKET_BYTES = 16'd65025;
  localparam logic [START_W-1:0] MAX_PACKET_START = 17'h1FFFF;
  localparam logic [7:0]         LACE_CONT        = 8'd255;
  localparam logic [SIZE_W-1:0]  CUT_PAD          = 16'd4;
  localparam logic [FRAME_W-1:0] FRAME_LENGTH_RST = 16'd16384;

  // Input op codes
  localparam logic [1:0] OP_PAGE_START = 2'd0;
  localparam logic [1:0] OP_LACING     = 2'd1;
  localparam logic [1:0] OP_PAGE_END   = 2'd2;

  // Event kinds, front to back
  localparam logic [1:0] EV_FULL = 2'd0;
  localparam logic [1:0] EV_CUT  = 2'd1;
  localparam logic [1:0] EV_EOS  = 2'd2;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_OFFSET = 1'b1;

  typedef struct packed {
    logic [1:0]          op;
    logic [OFFSET_W-1:0] page_base;
    logic                page_continued;
    logic [7:0]          lacing_value;
    logic                last_lacing;
    logic                packet_head_bit;
    logic                end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] sample_offset;
    logic [SIZE_W-1:0]   sample_size;
    logic [DUR_W-1:0]    sample_duration;
    logic                not_sync;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [OFFSET_W-1:0] offset;
    logic [SIZE_W-1:0]   size;
    logic                not_sync;
  } ev_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_length;
    logic [DUR_W-1:0]   stream_offset_samples;
  } cfg_t;

endpackage

@@ sv/ogg_lacing_sample_splitter_top.sv @@
// Top level of the Ogg lacing sample splitter.
// Takes one beat per cycle while in_full is low (page start, lacing value or
// page end) and turns the lacing stream of video pages into sample references,
// one packet behind: a packet is emitted when the next one ends or when an
// end-of-stream page ends. The front end counts packet bytes and offsets and
// pushes one event per packet end or end-of-stream page end into a short event
// queue; the back end pops one event per cycle while the result queue has room,
// keeps the held packet and pushes results into the result queue. Sustained
// rate is one input beat per clock while results are popped; the limit is the
// back end, which retires one event per cycle unless the result queue is full.
// in_full rises only when the event queue fills, which happens when results
// are not popped. The cut-packet share is an exact reciprocal multiply (one
// 31x32 product) in the back end. Config writes take effect the cycle after
// cfg_we and must only be done while no beats are in flight.
module ogg_lacing_sample_splitter_top #(
  parameter int unsigned SEGMENT_DIVISOR = ogls_pkg::SEGMENT_DIVISOR_DEF,
  parameter int unsigned EV_QUEUE_DEPTH  = ogls_pkg::EV_QUEUE_DEPTH_DEF,
  parameter int unsigned OUT_QUEUE_DEPTH = ogls_pkg::OUT_QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input queue side
  input  logic                                in_push,
  output logic                                in_full,
  input  ogls_pkg::in_item_t                  in_item,
  // result queue side
  output logic                                out_empty,
  input  logic                                out_pop,
  output ogls_pkg::out_item_t                 out_item,
  // config writes
  input  logic                                cfg_we,
  input  logic [ogls_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ogls_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ogls_pkg::*;

  cfg_t      cfg_r;
  ev_t       ev_in, ev_out;
  logic      ev_push, ev_full, ev_empty, ev_pop;
  out_item_t res_in;
  logic      res_push, res_full;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length          <= FRAME_LENGTH_RST;
      cfg_r.stream_offset_samples <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_LENGTH:  cfg_r.frame_length          <= cfg_wdata[FRAME_W-1:0];
        CFG_STREAM_OFFSET: cfg_r.stream_offset_samples <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end: a beat is taken whenever the event queue has room
  assign in_full = ev_full;

  ogls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .ev_full (ev_full),
    .ev_push (ev_push),
    .ev_data (ev_in)
  );

  ogls_fifo #(
    .W     ($bits(ev_t)),
    .DEPTH (EV_QUEUE_DEPTH)
  ) u_ev_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .din   (ev_in),
    .full  (ev_full),
    .pop   (ev_pop),
    .dout  (ev_out),
    .empty (ev_empty)
  );

  ogls_back #(
    .SEGMENT_DIVISOR (SEGMENT_DIVISOR)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .ev       (ev_out),
    .ev_empty (ev_empty),
    .ev_pop   (ev_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_in)
  );

  // result queue decouples the back end from out_pop
  ogls_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule

@@ sv/ogls_fifo.sv @@
// Small register FIFO used for the event queue and the result queue.
module ogls_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok, pop_ok;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

@@ sv/ogls_front.sv @@
// Front end: takes input beats, tracks page/packet byte counts, emits packet events.
module ogls_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  ogls_pkg::in_item_t in_item,
  input  logic              ev_full,
  output logic              ev_push,
  output ogls_pkg::ev_t     ev_data
);
  import ogls_pkg::*;

  logic [OFFSET_W-1:0] base_r, base_nxt;
  logic                flag_r, flag_nxt;
  logic [SIZE_W-1:0]   bytes_r, bytes_nxt;
  logic [START_W-1:0]  start_r, start_nxt;

  logic                accept;
  logic [SIZE_W:0]     bytes_sum;
  logic [SIZE_W-1:0]   bytes_sat;
  logic                is_cut;
  logic                pkt_end;
  logic [SIZE_W-1:0]   pkt_size;
  logic [START_W:0]    start_sum;
  logic [START_W-1:0]  start_sat;

  assign accept = in_push && !ev_full;

  always_comb begin
    bytes_sum = {1'b0, bytes_r} + {{(SIZE_W-7){1'b0}}, in_item.lacing_value};
    bytes_sat = (bytes_sum > {1'b0, MAX_PACKET_BYTES}) ? MAX_PACKET_BYTES
                                                       : bytes_sum[SIZE_W-1:0];
    is_cut    = in_item.last_lacing && (in_item.lacing_value == LACE_CONT);
    pkt_end   = (in_item.lacing_value != LACE_CONT) || in_item.last_lacing;
    // cut packets never exceed 65025 + 4, so no carry out
    pkt_size  = bytes_sat + (is_cut ? CUT_PAD : '0);
    start_sum = {1'b0, start_r} + {{(START_W-SIZE_W+1){1'b0}}, pkt_size};
    start_sat = (start_sum > {1'b0, MAX_PACKET_START}) ? MAX_PACKET_START
                                                       : start_sum[START_W-1:0];

    ev_data.kind     = is_cut ? EV_CUT : EV_FULL;
    ev_data.offset   = base_r + {{(OFFSET_W-START_W){1'b0}}, start_r};
    ev_data.size     = pkt_size;
    ev_data.not_sync = flag_r || (pkt_size == '0) || in_item.packet_head_bit;

    base_nxt  = base_r;
    flag_nxt  = flag_r;
    bytes_nxt = bytes_r;
    start_nxt = start_r;
    ev_push   = 1'b0;

    unique case (in_item.op)
      OP_PAGE_START: begin
        base_nxt  = in_item.page_base;
        flag_nxt  = in_item.page_continued;
        bytes_nxt = '0;
        start_nxt = '0;
      end
      OP_LACING: begin
        if (pkt_end) begin
          ev_push   = accept;
          bytes_nxt = '0;
          start_nxt = start_sat;
          flag_nxt  = 1'b0;
        end else begin
          bytes_nxt = bytes_sat;
        end
      end
      OP_PAGE_END: begin
        if (in_item.end_of_stream) begin
          ev_data.kind = EV_EOS;
          ev_push      = accept;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      flag_r  <= 1'b0;
      bytes_r <= '0;
      start_r <= '0;
    end else if (accept) begin
      base_r  <= base_nxt;
      flag_r  <= flag_nxt;
      bytes_r <= bytes_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

@@ sv/ogls_back.sv @@
// Back end: holds one packet, assigns durations and emits sample references.
module ogls_back #(
  parameter int unsigned SEGMENT_DIVISOR = ogls_pkg::SEGMENT_DIVISOR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ogls_pkg::cfg_t      cfg,
  input  ogls_pkg::ev_t       ev,
  input  logic                ev_empty,
  output logic                ev_pop,
  input  logic                out_full,
  output logic                out_push,
  output ogls_pkg::out_item_t out_data
);
  import ogls_pkg::*;

  // Exact divide of a 31-bit value by the constant: x * M >> S
  localparam int unsigned   DIV_K = $clog2(SEGMENT_DIVISOR);
  localparam int unsigned   DIV_S = DUR_W + DIV_K;
  localparam logic [63:0]   DIV_M = ((64'd1 << DIV_S) / SEGMENT_DIVISOR) + 64'd1;
  localparam logic [31:0]   DIV_M32 = DIV_M[31:0];

  logic                held_valid_r;
  logic [OFFSET_W-1:0] held_offset_r;
  logic [SIZE_W-1:0]   held_size_r;
  logic [HDUR_W-1:0]   held_dur_r, held_dur_nxt;
  logic                held_ns_r;

  logic                dur_pos;
  logic [DUR_W+31:0]   prod;
  logic [DUR_W+31:0]   prod_sh;
  logic [DUR_W-1:0]    quot;
  logic [DUR_W-1:0]    share;
  logic [HDUR_W-1:0]   frame_ext;
  logic                emit;
  logic                update;
  logic [DUR_W-1:0]    dur_out;

  assign ev_pop    = !ev_empty && !out_full;
  assign frame_ext = {{(HDUR_W-FRAME_W){1'b0}}, cfg.frame_length};
  assign dur_pos   = (held_dur_r != '0) && !held_dur_r[HDUR_W-1];
  assign prod      = {32'b0, held_dur_r[DUR_W-1:0]} * {{DUR_W{1'b0}}, DIV_M32};
  assign prod_sh   = prod >> DIV_S;
  assign quot      = prod_sh[DUR_W-1:0];
  assign share     = (quot == '0) ? DUR_W'(1) : quot;

  always_comb begin
    emit         = 1'b0;
    update       = 1'b0;
    dur_out      = DUR_W'(1);
    // first packet of the stream
    held_dur_nxt = frame_ext + {1'b0, cfg.stream_offset_samples};
    unique case (ev.kind)
      EV_EOS: begin
        emit = held_valid_r;
        if (dur_pos) begin
          dur_out = held_dur_r[DUR_W-1:0];
        end
      end
      EV_FULL: begin
        update = 1'b1;
        if (held_valid_r) begin
          emit = 1'b1;
          if (dur_pos) begin
            dur_out      = held_dur_r[DUR_W-1:0];
            held_dur_nxt = frame_ext;
          end else begin
            held_dur_nxt = frame_ext + held_dur_r - HDUR_W'(1);
          end
        end
      end
      EV_CUT: begin
        update = 1'b1;
        if (held_valid_r) begin
          emit = 1'b1;
          if (dur_pos) begin
            dur_out      = share;
            held_dur_nxt = held_dur_r - {1'b0, share};
          end else begin
            held_dur_nxt = held_dur_r - HDUR_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_push = ev_pop && emit;

  always_comb begin
    out_data.sample_offset   = held_offset_r;
    out_data.sample_size     = held_size_r;
    out_data.sample_duration = dur_out;
    out_data.not_sync        = held_ns_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (ev_pop && update) begin
      held_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop && update) begin
      held_offset_r <= ev.offset;
      held_size_r   <= ev.size + 1'b1;
      held_dur_r    <= held_dur_nxt;
      held_ns_r     <= ev.not_sync;
    end
  end

endmodule

@@ sv/ogls_checker.sv @@
// Port-level checks of the splitter, bound to the top level.
module ogls_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input ogls_pkg::out_item_t out_item
);

  // reset leaves the result queue empty and the event queue not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting result beat is neither lost nor changed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result beat dropped or changed");

  // every sample carries the padding byte and a nonzero duration
  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.sample_size != '0 && out_item.sample_duration != '0)
    else $error("result with zero size or duration");

endmodule

bind ogg_lacing_sample_splitter_top ogls_checker u_ogls_checker (.*);
